FILE: sv/radiotap_header_field_extractor_defines.svh
// Assertion macros shared by the radiotap header field extractor modules.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef RADIOTAP_HEADER_FIELD_EXTRACTOR_DEFINES_SVH
`define RADIOTAP_HEADER_FIELD_EXTRACTOR_DEFINES_SVH

// Checks that an expression holds at every clock edge outside reset.
`define RHFE_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define RHFE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define RHFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rhfe_pkg.sv
// Package of the radiotap header field extractor: item type, header constants
// and the field offset function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rhfe_pkg;

   typedef logic [15:0] pos_type;

   // Fixed byte positions of the radiotap header.
   localparam pos_type HDR_LEN_LO_POS  = 16'd2;
   localparam pos_type HDR_LEN_HI_POS  = 16'd3;
   localparam pos_type PRESENT_POS     = 16'd4;
   localparam pos_type PRESENT_TOP_POS = 16'd7;
   localparam pos_type FIELD_BASE_POS  = 16'd8;
   localparam pos_type POS_MAX         = 16'hFFFF;
   localparam logic [16:0] MIN_PKT_LEN = 17'd8;
   localparam logic [16:0] EXT_WORD_LEN = 17'd4;
   localparam logic [16:0] EXT_WORD_TOP = 17'd3;

   // Bit of the flags byte that marks a trailing FCS.
   localparam int FLAG_FCS_BIT = 4;
   // Bit 31 of a present word sits in bit 7 of its top byte.
   localparam int PRESENT_EXT_BIT = 7;

   // Present bitmap bits that are tracked.
   localparam int PRES_TSFT    = 0;
   localparam int PRES_FLAGS   = 1;
   localparam int PRES_RATE    = 2;
   localparam int PRES_CHANNEL = 3;
   localparam int PRES_FHSS    = 4;
   localparam int PRES_SIGNAL  = 5;

   // One classified packet byte travelling from the front to the back.
   typedef struct packed {
      logic [7:0] data;
      logic       cap_fcs;
      logic       cap_sig;
      logic       last;
      logic       short_pkt;
   } item_type;

   // Field positions relative to the 8-byte aligned base of the field area.
   typedef struct packed {
      logic [4:0] flags_off;
      logic [4:0] sig_off;
   } offs_type;

   // Walks the fixed-size fields that precede the signal byte. Alignment is
   // preserved because the base that these offsets add to is a multiple of 8.
   function automatic offs_type field_offsets(input logic [2:0] start_lo,
                                              input logic [5:0] present);
      logic [4:0] p;
      offs_type   o;
      p = {2'b00, start_lo};
      if (present[PRES_TSFT]) begin
         p = ((p + 5'd7) & 5'b11000) + 5'd8;
      end
      o.flags_off = p;
      if (present[PRES_FLAGS]) begin
         p = p + 5'd1;
      end
      if (present[PRES_RATE]) begin
         p = p + 5'd1;
      end
      if (present[PRES_CHANNEL]) begin
         p = ((p + 5'd1) & 5'b11110) + 5'd4;
      end
      if (present[PRES_FHSS]) begin
         p = p + 5'd2;
      end
      o.sig_off = p;
      return o;
   endfunction

endpackage

`default_nettype wire

FILE: sv/rhfe_channels.sv
// Handshake channels of the radiotap header field extractor: packet bytes in,
// parse results out. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface rhfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rhfe_rsp_if;
   logic              valid;
   logic              ready;
   logic              has_fcs;
   logic signed [7:0] signal_dbm;
   logic              signal_valid;

   modport source (output valid, output has_fcs, output signal_dbm, output signal_valid,
                   input ready);
   modport sink (input valid, input has_fcs, input signal_dbm, input signal_valid,
                 output ready);
endinterface

`default_nettype wire

FILE: sv/radiotap_header_field_extractor.sv
// Top level of the radiotap header field extractor: front classifier, queue
// and back part. Depends on rhfe_pkg, rhfe_channels and the three submodules.
//
//   Channel   Direction  Moves
//   req_ch    in         one packet byte and its last-byte mark per item
//   rsp_ch    out        has_fcs, signal_dbm, signal_valid once per packet
//
// One byte is accepted per cycle while the queue is not full; a packet's last
// byte passes through the queue and the back builds its result in the output
// register when it is free. The front compares the byte position with the
// header layout combinationally; the back applies the captures via a two-entry queue.
// Reset is synchronous and clears positions, queue and capture state at once.
// A stalled result holds only a last byte in the back; the queue then fills
// and req_ch.ready drops until rsp_ch takes the result.
`timescale 1ns / 1ps
`default_nettype none

module radiotap_header_field_extractor import rhfe_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rhfe_req_if.sink   req_ch,
   rhfe_rsp_if.source rsp_ch
);

   item_type front_item;
   item_type back_item;
   logic     accept;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;

   // Input handshake: bytes go straight into the queue.
   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;

   rhfe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_ch.data_byte),
      .last_byte (req_ch.last_byte),
      .item      (front_item)
   );

   rhfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (back_item),
      .empty     (q_empty)
   );

   rhfe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (!q_empty),
      .item             (back_item),
      .pop              (q_pop),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_has_fcs      (rsp_ch.has_fcs),
      .rsp_signal_dbm   (rsp_ch.signal_dbm),
      .rsp_signal_valid (rsp_ch.signal_valid)
   );

endmodule

`default_nettype wire

FILE: sv/rhfe_front.sv
// Front part: tracks the byte position and header layout and classifies each
// accepted byte. Depends on rhfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhfe_front import rhfe_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   output item_type        item
);

   pos_type    pos_ff, pos_in;
   pos_type    hlen_ff, hlen_in;
   logic [5:0] present_ff, present_in;
   logic       ext_ff, ext_in;
   pos_type    fstart_ff, fstart_in;

   logic        past_base;
   logic        fit_fail;
   logic        ext_word_end;
   logic        fields_live;
   offs_type    offs;
   logic [16:0] pos17, hl17, base17, flags_pos, sig_pos, length;
   logic        has_flags, flags_fit, flags_ok;

   // Common widened views of the position and header length.
   assign pos17       = {1'b0, pos_ff};
   assign hl17        = {1'b0, hlen_ff};
   assign past_base   = pos_ff >= FIELD_BASE_POS;
   assign fit_fail    = ({1'b0, fstart_ff} + EXT_WORD_LEN) > hl17;
   assign ext_word_end = pos17 == ({1'b0, fstart_ff} + EXT_WORD_TOP);

   // Field placement is active once the extension words are behind us. On the
   // byte that ends an extension word no field can lie, so it is left out.
   assign fields_live = past_base && (!ext_ff || fit_fail);

   // Header length, present bits and extension word skipping.
   always_comb begin
      hlen_in    = hlen_ff;
      present_in = present_ff;
      ext_in     = ext_ff;
      fstart_in  = fstart_ff;
      if (pos_ff == HDR_LEN_LO_POS) begin
         hlen_in = {hlen_ff[15:8], data_byte};
      end
      if (pos_ff == HDR_LEN_HI_POS) begin
         hlen_in = {data_byte, hlen_ff[7:0]};
      end
      if (pos_ff == PRESENT_POS) begin
         present_in = data_byte[5:0];
      end
      if (pos_ff == PRESENT_TOP_POS) begin
         ext_in = data_byte[PRESENT_EXT_BIT];
      end
      if (past_base && ext_ff) begin
         if (fit_fail) begin
            ext_in = 1'b0;
         end else if (ext_word_end) begin
            ext_in    = data_byte[PRESENT_EXT_BIT];
            fstart_in = fstart_ff + 16'd4;
         end
      end
   end

   // Positions of the flags and signal bytes.
   assign offs      = field_offsets(fstart_ff[2:0], present_ff);
   assign base17    = {1'b0, fstart_ff[15:3], 3'b000};
   assign flags_pos = base17 + {12'd0, offs.flags_off};
   assign sig_pos   = base17 + {12'd0, offs.sig_off};
   assign has_flags = present_ff[PRES_FLAGS];
   assign flags_fit = flags_pos < hl17;
   assign flags_ok  = !has_flags || flags_fit;
   assign length    = pos17 + 17'd1;

   // Classification of the current byte.
   always_comb begin
      item.data      = data_byte;
      item.last      = last_byte;
      item.cap_fcs   = fields_live && has_flags && flags_fit && (pos17 == flags_pos);
      item.cap_sig   = fields_live && flags_ok && present_ff[PRES_SIGNAL] &&
                       (sig_pos < hl17) && (pos17 == sig_pos);
      item.short_pkt = (length < MIN_PKT_LEN) || (length < hl17);
   end

   // The position saturates; the last byte of a packet restores the reset state.
   assign pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         pos_ff     <= '0;
         hlen_ff    <= '0;
         present_ff <= '0;
         ext_ff     <= 1'b0;
         fstart_ff  <= FIELD_BASE_POS;
      end else if (accept) begin
         pos_ff     <= pos_in;
         hlen_ff    <= hlen_in;
         present_ff <= present_in;
         ext_ff     <= ext_in;
         fstart_ff  <= fstart_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/rhfe_queue.sv
// Short queue of classified bytes between the front and the back part.
// Depends on rhfe_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "radiotap_header_field_extractor_defines.svh"

module rhfe_queue import rhfe_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  item_type  push_item,
   output logic      full,
   input  wire logic pop,
   output item_type  pop_item,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == FULL_CNT;
   assign empty    = count_ff == '0;
   assign pop_item = slot_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Occupancy stays in range and grows on a push without a pop.
   `RHFE_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= FULL_CNT, "queue overfilled")
   `RHFE_ASSERT_NEXT(a_count_grow, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not grow")

endmodule

`default_nettype wire

FILE: sv/rhfe_back.sv
// Back part: applies the captures of each classified byte and builds the
// result at a packet's last byte in an output register. Depends on rhfe_pkg
// and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "radiotap_header_field_extractor_defines.svh"

module rhfe_back import rhfe_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         item_valid,
   input  item_type          item,
   output logic              pop,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_has_fcs,
   output logic signed [7:0] rsp_signal_dbm,
   output logic              rsp_signal_valid
);

   logic              fcs_ff, fcs_in;
   logic [7:0]        sigv_ff, sigv_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              has_fcs_ff;
   logic signed [7:0] dbm_ff;
   logic              sig_ok_ff;
   logic              out_free;
   logic              emit;
   logic              keep;

   // A last byte waits until the output register is free or being emptied.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = item_valid && (!item.last || out_free);
   assign emit     = pop && item.last;
   assign keep     = !item.short_pkt;

   // Captures of the current byte.
   always_comb begin
      fcs_in   = item.cap_fcs ? item.data[FLAG_FCS_BIT] : fcs_ff;
      sigv_in  = item.cap_sig ? item.data : sigv_ff;
      found_in = item.cap_sig ? 1'b1 : found_ff;
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Per-packet capture state, cleared when the result is built.
   always_ff @(posedge clock) begin
      if (reset || emit) begin
         fcs_ff   <= 1'b0;
         sigv_ff  <= '0;
         found_ff <= 1'b0;
      end else if (pop) begin
         fcs_ff   <= fcs_in;
         sigv_ff  <= sigv_in;
         found_ff <= found_in;
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; a short packet gives all zero.
   always_ff @(posedge clock) begin
      if (emit) begin
         has_fcs_ff <= keep && fcs_in;
         dbm_ff     <= (keep && found_in) ? sigv_in : 8'sd0;
         sig_ok_ff  <= keep && found_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_has_fcs      = has_fcs_ff;
   assign rsp_signal_dbm   = dbm_ff;
   assign rsp_signal_valid = sig_ok_ff;

   // A waiting result is never overwritten, and an absent signal reads as zero.
   `RHFE_ASSERT_IMPLIES(a_no_overwrite, clock, reset, emit, out_free, "result overwritten")
   `RHFE_ASSERT_IMPLIES(a_sig_clear, clock, reset, !found_ff, sigv_ff == 8'd0, "stale signal value")
   `RHFE_ASSERT_IMPLIES(a_dbm_zero, clock, reset, rsp_valid_ff && !sig_ok_ff, dbm_ff == 8'sd0, "signal without valid")

endmodule

`default_nettype wire
